// ----- src/mpq_pkg.sv -----
package mpq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = 7;
	localparam int KEY_W = 32;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELMIN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} mpq_cmd_t;

	typedef struct packed {
		logic last_addr;
	} mpq_stat_t;

endpackage

// ----- src/mpq_ctrl.sv -----
module mpq_ctrl
	import mpq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [KIND_W-1:0]  kind,
	output logic               out_valid,
	input  logic               out_ready,
	output mpq_cmd_t           cmd,
	input  mpq_stat_t          stat
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = (kind == KIND_CLEAR) ? ST_COMMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accept while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
		else $error("result outside commit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.commit)
		else $error("pending result overwritten");

endmodule

// ----- src/mpq_dp.sv -----
module mpq_dp
	import mpq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  mpq_cmd_t                 cmd,
	output mpq_stat_t                stat,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [KEY_W-1:0]  key,
	output logic [STAT_W-1:0]        status,
	output logic signed [KEY_W-1:0]  removed_key,
	output logic signed [KEY_W-1:0]  min_key,
	output logic                     empty_res,
	output logic [CNT_W-1:0]         count
);

	logic signed [KEY_W-1:0] mem [CAPACITY];

	logic [KIND_W-1:0]       op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [IDX_W-1:0]        idx_q;
	logic [CAPACITY-1:0]     valid_q;
	logic [CNT_W-1:0]        count_q;

	logic signed [KEY_W-1:0] rd_data_s1;
	logic                    entry_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    eval_s1;

	logic                    has_best_q;
	logic signed [KEY_W-1:0] best_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic                    has_sec_q;
	logic signed [KEY_W-1:0] sec_q;
	logic                    has_free_q;
	logic [IDX_W-1:0]        free_idx_q;

	logic [STAT_W-1:0]       status_q;
	logic signed [KEY_W-1:0] removed_q;
	logic signed [KEY_W-1:0] min_q;
	logic                    empty_q;

	logic [STAT_W-1:0]       nxt_status;
	logic signed [KEY_W-1:0] nxt_removed;
	logic signed [KEY_W-1:0] nxt_min;
	logic [CNT_W-1:0]        nxt_count;
	logic                    ins_ok;
	logic                    del_ok;
	logic                    mem_we;

	assign stat.last_addr = (idx_q == IDX_W'(CAPACITY - 1));
	assign ins_ok = (op_q == KIND_INSERT) && has_free_q;
	assign del_ok = (op_q == KIND_DELMIN) && has_best_q;
	assign mem_we = cmd.commit && ins_ok;

	assign status = status_q;
	assign removed_key = removed_q;
	assign min_key = min_q;
	assign empty_res = empty_q;
	assign count = count_q;

	// key store, one read port for the scan, one write port for insert
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[free_idx_q] <= key_q;
		end
		if (cmd.scan) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= kind;
			key_q <= key;
		end
		if (cmd.scan) begin
			entry_s1 <= valid_q[idx_q];
			idx_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= cmd.scan;
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// least and second least valid key, lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_best_q <= 1'b0;
			best_q <= '0;
			best_idx_q <= '0;
			has_sec_q <= 1'b0;
			sec_q <= '0;
			has_free_q <= 1'b0;
			free_idx_q <= '0;
		end else if (cmd.start) begin
			has_best_q <= 1'b0;
			has_sec_q <= 1'b0;
			has_free_q <= 1'b0;
		end else if (eval_s1) begin
			if (entry_s1) begin
				if (!has_best_q || (rd_data_s1 < best_q)) begin
					has_sec_q <= has_best_q;
					sec_q <= best_q;
					has_best_q <= 1'b1;
					best_q <= rd_data_s1;
					best_idx_q <= idx_s1;
				end else if (!has_sec_q || (rd_data_s1 < sec_q)) begin
					has_sec_q <= 1'b1;
					sec_q <= rd_data_s1;
				end
			end else if (!has_free_q) begin
				has_free_q <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
	end

	always_comb begin
		nxt_status = STAT_OK;
		nxt_removed = '0;
		nxt_min = has_best_q ? best_q : '0;
		nxt_count = count_q;
		unique case (op_q)
			KIND_INSERT: begin
				if (has_free_q) begin
					nxt_count = count_q + CNT_W'(1);
					if (!has_best_q || (key_q < best_q)) begin
						nxt_min = key_q;
					end
				end else begin
					nxt_status = STAT_FULL;
				end
			end
			KIND_DELMIN: begin
				if (has_best_q) begin
					nxt_removed = best_q;
					nxt_min = has_sec_q ? sec_q : '0;
					nxt_count = count_q - CNT_W'(1);
				end else begin
					nxt_status = STAT_EMPTY;
				end
			end
			KIND_CLEAR: begin
				nxt_min = '0;
				nxt_count = '0;
			end
			default: begin
				nxt_status = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= nxt_count;
			if (op_q == KIND_CLEAR) begin
				valid_q <= '0;
			end else if (ins_ok) begin
				valid_q[free_idx_q] <= 1'b1;
			end else if (del_ok) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= nxt_status;
			removed_q <= nxt_removed;
			min_q <= nxt_min;
			empty_q <= (nxt_count == '0);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count out of step with valid bits");

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= CAPACITY)
		else $error("entry count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && del_ok) |=> !valid_q[$past(best_idx_q)])
		else $error("deleted slot still valid");

endmodule

// ----- src/min_priority_queue_unordered_unit.sv -----
// Min priority queue over an unordered store of 64 signed 32-bit keys. Each request
// is an insert, a delete of the least key or a clear, and gives one result with a
// status, the removed key, the least key after the step, an empty flag and the count.
// Insert, delete and the unused kind scan the whole store through the single read
// port of the key memory, one entry a cycle: accept, a read of each entry, a drain
// step for the last read, then commit once the output is free; a clear goes straight from
// accept to commit. The next request is accepted while a result waits at the output.
module min_priority_queue_unordered_unit
	import mpq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [KEY_W-1:0]  key,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic signed [KEY_W-1:0]  removed_key,
	output logic signed [KEY_W-1:0]  min_key,
	output logic                     empty_res,
	output logic [CNT_W-1:0]         count
);

	mpq_cmd_t  cmd;
	mpq_stat_t stat;

	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	mpq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.key         (key),
		.status      (status),
		.removed_key (removed_key),
		.min_key     (min_key),
		.empty_res   (empty_res),
		.count       (count)
	);

endmodule

// ----- bench/min_priority_queue_unordered_unit_test.sv -----
`timescale 1ns / 1ps

module min_priority_queue_unordered_unit_test;
	import mpq_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int ITEMS = 1350;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_CYCLES = 100;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [KEY_W-1:0] removed;
		logic signed [KEY_W-1:0] least;
		logic                    is_empty;
		logic [CNT_W-1:0]        count;
	} mpq_result_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [KEY_W-1:0] key;
		logic                    typed;
		mpq_result_t             want;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [KIND_W-1:0]       kind = KIND_INSERT;
	logic signed [KEY_W-1:0] key = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [STAT_W-1:0]       status;
	logic signed [KEY_W-1:0] removed_key;
	logic signed [KEY_W-1:0] min_key;
	logic                    empty_res;
	logic [CNT_W-1:0]        count;

	// shadow copy of the store
	logic signed [KEY_W-1:0] slot_key [CAPACITY];
	logic [CAPACITY-1:0]     slot_used = '0;
	int unsigned             n_stored = 0;

	mpq_result_t pending_results [$];
	mpq_result_t head_result;
	dir_row_t    dir_rows [$];
	int          n_errors = 0;
	int          n_checked = 0;
	int          n_sent = 0;
	int          idle_cycles = 0;
	bit          quiet = 1'b0;
	bit          hold_off_req = 1'b0;

	min_priority_queue_unordered_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.removed_key(removed_key),
		.min_key(min_key),
		.empty_res(empty_res),
		.count(count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int least_slot();
		int best;
		best = -1;
		for (int i = 0; i < CAPACITY; i++)
			if (slot_used[i] && (best < 0 || slot_key[i] < slot_key[best]))
				best = i;
		return best;
	endfunction

	function automatic mpq_result_t apply_request(logic [KIND_W-1:0] k,
			logic signed [KEY_W-1:0] v);
		mpq_result_t r;
		int slot;
		r = '0;
		r.status = STAT_OK;
		slot = -1;
		case (k)
			KIND_INSERT: begin
				for (int i = CAPACITY - 1; i >= 0; i--)
					if (!slot_used[i])
						slot = i;
				if (slot < 0) begin
					r.status = STAT_FULL;
				end else begin
					slot_key[slot] = v;
					slot_used[slot] = 1'b1;
					n_stored++;
				end
			end
			KIND_DELMIN: begin
				slot = least_slot();
				if (slot < 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.removed = slot_key[slot];
					slot_used[slot] = 1'b0;
					n_stored--;
				end
			end
			KIND_CLEAR: begin
				slot_used = '0;
				n_stored = 0;
			end
			default: ;
		endcase
		slot = least_slot();
		if (slot >= 0)
			r.least = slot_key[slot];
		r.is_empty = (n_stored == 0);
		r.count = CNT_W'(n_stored);
		return r;
	endfunction

	function automatic dir_row_t dir_row(logic [KIND_W-1:0] k, logic signed [KEY_W-1:0] v,
			logic typed, logic [STAT_W-1:0] st, logic signed [KEY_W-1:0] rem,
			logic signed [KEY_W-1:0] lst, logic emp, logic [CNT_W-1:0] cnt);
		dir_row_t d;
		d.kind = k;
		d.key = v;
		d.typed = typed;
		d.want.status = st;
		d.want.removed = rem;
		d.want.least = lst;
		d.want.is_empty = emp;
		d.want.count = cnt;
		return d;
	endfunction

	function automatic logic signed [KEY_W-1:0] random_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 32'sh8000_0000;
		if (r < 8)
			return 32'sh7fff_ffff;
		if (r < 35)
			return $signed($urandom_range(0, 16)) - 8;
		return $urandom;
	endfunction

	function automatic logic [KIND_W-1:0] random_kind();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 48)
			return KIND_INSERT;
		if (r < 93)
			return KIND_DELMIN;
		if (r < 98)
			return KIND_CLEAR;
		return KIND_UNUSED;
	endfunction

	task automatic send_request(input logic [KIND_W-1:0] k, input logic signed [KEY_W-1:0] v,
			input logic typed, input mpq_result_t typed_result);
		mpq_result_t predicted;
		while (!quiet && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		key <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = apply_request(k, v);
		pending_results.push_back(typed ? typed_result : predicted);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic report_mismatch(string msg);
		$display("%0t ERROR result %0d: %s", $time, n_checked, msg);
		n_errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				head_result = pending_results.pop_front();
				if (status !== head_result.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						status, head_result.status));
				if (removed_key !== head_result.removed)
					report_mismatch($sformatf("removed_key got %0d expected %0d",
						removed_key, head_result.removed));
				if (min_key !== head_result.least)
					report_mismatch($sformatf("min_key got %0d expected %0d",
						min_key, head_result.least));
				if (empty_res !== head_result.is_empty)
					report_mismatch($sformatf("empty_res got %0d expected %0d",
						empty_res, head_result.is_empty));
				if (count !== head_result.count)
					report_mismatch($sformatf("count got %0d expected %0d",
						count, head_result.count));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side backpressure
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			out_ready <= quiet || ($urandom_range(0, 99) >= 33);
		end
	end

	initial begin
		int phase;
		int unsigned pick;
		for (int i = 0; i < CAPACITY; i++)
			slot_key[i] = '0;

		dir_rows.push_back(dir_row(KIND_DELMIN, 32'sd0, 1'b1, STAT_EMPTY,
			32'sd0, 32'sd0, 1'b1, 7'd0));
		dir_rows.push_back(dir_row(KIND_UNUSED, 32'sh7fff_ffff, 1'b1, STAT_OK,
			32'sd0, 32'sd0, 1'b1, 7'd0));
		dir_rows.push_back(dir_row(KIND_CLEAR, 32'sd0, 1'b1, STAT_OK,
			32'sd0, 32'sd0, 1'b1, 7'd0));
		dir_rows.push_back(dir_row(KIND_INSERT, 32'sh7fff_ffff, 1'b1, STAT_OK,
			32'sd0, 32'sh7fff_ffff, 1'b0, 7'd1));
		dir_rows.push_back(dir_row(KIND_INSERT, 32'sh8000_0000, 1'b1, STAT_OK,
			32'sd0, 32'sh8000_0000, 1'b0, 7'd2));
		dir_rows.push_back(dir_row(KIND_INSERT, -32'sd1, 1'b0, STAT_OK,
			32'sd0, 32'sd0, 1'b0, 7'd0));
		dir_rows.push_back(dir_row(KIND_INSERT, 32'sd0, 1'b0, STAT_OK,
			32'sd0, 32'sd0, 1'b0, 7'd0));
		dir_rows.push_back(dir_row(KIND_INSERT, 32'sh8000_0000, 1'b0, STAT_OK,
			32'sd0, 32'sd0, 1'b0, 7'd0));
		dir_rows.push_back(dir_row(KIND_INSERT, 32'sh5555_5555, 1'b0, STAT_OK,
			32'sd0, 32'sd0, 1'b0, 7'd0));
		dir_rows.push_back(dir_row(KIND_INSERT, 32'shaaaa_aaaa, 1'b0, STAT_OK,
			32'sd0, 32'sd0, 1'b0, 7'd0));
		dir_rows.push_back(dir_row(KIND_UNUSED, -32'sd1, 1'b0, STAT_OK,
			32'sd0, 32'sd0, 1'b0, 7'd0));
		repeat (7)
			dir_rows.push_back(dir_row(KIND_DELMIN, 32'sd0, 1'b0, STAT_OK,
				32'sd0, 32'sd0, 1'b0, 7'd0));
		dir_rows.push_back(dir_row(KIND_DELMIN, -32'sd1, 1'b1, STAT_EMPTY,
			32'sd0, 32'sd0, 1'b1, 7'd0));
		dir_rows.push_back(dir_row(KIND_INSERT, 32'sd1, 1'b0, STAT_OK,
			32'sd0, 32'sd0, 1'b0, 7'd0));
		dir_rows.push_back(dir_row(KIND_INSERT, 32'sd1, 1'b0, STAT_OK,
			32'sd0, 32'sd0, 1'b0, 7'd0));
		dir_rows.push_back(dir_row(KIND_DELMIN, 32'sd0, 1'b0, STAT_OK,
			32'sd0, 32'sd0, 1'b0, 7'd0));
		dir_rows.push_back(dir_row(KIND_CLEAR, 32'sd5, 1'b1, STAT_OK,
			32'sd0, 32'sd0, 1'b1, 7'd0));

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].typed,
				dir_rows[i].want);
		drain_results();

		phase = 0;
		while (n_sent < ITEMS) begin
			phase++;
			quiet = (n_sent >= 600 && n_sent < 850);
			if (phase == 2)
				hold_off_req = 1'b1;
			pick = (phase == 1) ? 0 : $urandom_range(0, 9);
			if (pick < 3) begin
				// fill to capacity, then push past it
				while (n_stored < CAPACITY)
					send_request(($urandom_range(0, 9) == 0) ? KIND_DELMIN : KIND_INSERT,
						random_key(), 1'b0, '0);
				repeat ($urandom_range(1, 4))
					send_request(KIND_INSERT, random_key(), 1'b0, '0);
			end else if (pick < 5) begin
				// drain, then delete on empty
				while (n_stored > 0)
					send_request(($urandom_range(0, 7) == 0) ? KIND_INSERT : KIND_DELMIN,
						random_key(), 1'b0, '0);
				repeat ($urandom_range(1, 3))
					send_request(KIND_DELMIN, random_key(), 1'b0, '0);
			end else begin
				repeat ($urandom_range(20, 80))
					send_request(random_kind(), random_key(), 1'b0, '0);
			end
			if (phase == 3 || $urandom_range(0, 3) == 0)
				drain_results();
		end
		quiet = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
src/mpq_pkg.sv
src/mpq_ctrl.sv
src/mpq_dp.sv
src/min_priority_queue_unordered_unit.sv
bench/min_priority_queue_unordered_unit_test.sv
